// File: rtl/rrd_pkg.sv
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared types, widths and codes of the rice residual decoder.
// ----------------------------------------------------------------------------
package rrd_pkg;

  localparam int SAMPLE_BITS = 32;

  localparam int RES_W      = 32;
  localparam int RUN_W      = 16;
  localparam int ERR_W      = 2;
  localparam int BS_W       = 16;
  localparam int PO_W       = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRED_ORDER = 2'd1;

  localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_METHOD = 2'd1;
  localparam logic [ERR_W-1:0] ERR_PART   = 2'd2;

  localparam logic [4:0] PARAM_ESC4 = 5'h0F;
  localparam logic [4:0] PARAM_ESC5 = 5'h1F;
  localparam logic [4:0] METHOD_BITS = 5'd2;
  localparam logic [4:0] ORDER_BITS  = 5'd4;
  localparam logic [4:0] ESCW_BITS   = 5'd5;

  localparam logic [BS_W-1:0] BS_RESET = 16'd4096;

  typedef enum logic [3:0] {
    PH_METHOD,
    PH_ORDER,
    PH_PARAM,
    PH_UNARY,
    PH_LOW,
    PH_ESCW,
    PH_ESCS,
    PH_DONE,
    PH_HALT
  } phase_t;

  typedef struct packed {
    logic stream_bit;
    logic section_start;
  } in_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } qstat_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  cnt;
    logic [15:0] quot;
    logic [31:0] acc;
    logic [4:0]  kparam;
    logic        wide;
    logic [3:0]  order;
    logic [14:0] pidx;
    logic [15:0] left;
    logic [4:0]  escw;
    logic        esc;
  } pstate_t;

  localparam pstate_t PST_RESET = '{
    phase:  PH_METHOD,
    cnt:    5'd0,
    quot:   16'd0,
    acc:    32'd0,
    kparam: 5'd0,
    wide:   1'b0,
    order:  4'd0,
    pidx:   15'd0,
    left:   16'd0,
    escw:   5'd0,
    esc:    1'b0
  };

endpackage

// File: rtl/rrd_if.sv
// ----------------------------------------------------------------------------
// rrd_if
// Channel interfaces: stream bits in, residuals out, register writes.
// ----------------------------------------------------------------------------
interface rrd_in_if;
  logic valid;
  logic ready;
  logic stream_bit;
  logic section_start;

  modport source(output valid, output stream_bit, output section_start, input ready);
  modport sink(input valid, input stream_bit, input section_start, output ready);
endinterface

interface rrd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rrd_pkg::RES_W-1:0]  residual;
  logic        [rrd_pkg::RUN_W-1:0]  run_count;
  logic                              block_last;
  logic        [rrd_pkg::ERR_W-1:0]  error_code;

  modport source(output valid, output residual, output run_count, output block_last,
                 output error_code, input ready);
  modport sink(input valid, input residual, input run_count, input block_last,
               input error_code, output ready);
endinterface

interface rrd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rrd_pkg::CFG_IDX_W-1:0]      index;
  logic [rrd_pkg::CFG_DATA_W-1:0]     data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/rrd_front.sv
// ----------------------------------------------------------------------------
// rrd_front
// Input side: takes stream bit requests into a short queue for the parser.
// ----------------------------------------------------------------------------
module rrd_front (
  input  logic            clk,
  input  logic            rst_n,
  rrd_in_if.sink          in_ch,
  output rrd_pkg::qstat_t q_o,
  input  logic            pop
);
  import rrd_pkg::*;

  in_item_t         mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             push;
  logic             do_pop;

  assign in_ch.ready = (count_r != QCW'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign do_pop      = pop && (count_r != '0);

  assign q_o.valid = (count_r != '0);
  assign q_o.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCW'(push) - QCW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{stream_bit: in_ch.stream_bit, section_start: in_ch.section_start};
    end
  end

endmodule

// File: rtl/rrd_back.sv
// ----------------------------------------------------------------------------
// rrd_back
// Parser: one queued bit per cycle, unless a result stalls on out_ch,
// through the residual section syntax, with the block registers and the result register.
// ----------------------------------------------------------------------------
module rrd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rrd_pkg::qstat_t q_i,
  output logic            pop,
  rrd_out_if.source       out_ch,
  rrd_cfg_if.sink         cfg_ch
);
  import rrd_pkg::*;

  function automatic pstate_t f_clear(pstate_t s);
    pstate_t r;
    r      = s;
    r.cnt  = '0;
    r.acc  = '0;
    r.quot = '0;
    return r;
  endfunction

  function automatic pstate_t f_advance(pstate_t s, logic lastp);
    pstate_t r;
    r = f_clear(s);
    if (lastp) begin
      r.phase = PH_DONE;
    end else begin
      r.pidx  = s.pidx + 15'd1;
      r.phase = PH_PARAM;
    end
    return r;
  endfunction

  function automatic logic [31:0] f_wrap(logic [31:0] v);
    logic [31:0] r;
    r = v;
    for (int i = SAMPLE_BITS; i < 32; i++) begin
      r[i] = v[SAMPLE_BITS-1];
    end
    return r;
  endfunction

  function automatic logic [31:0] f_zigzag(logic [31:0] v);
    return {1'b0, v[31:1]} ^ {32{v[0]}};
  endfunction

  pstate_t          st_r, st_nxt, eff;
  logic [BS_W-1:0]  bs_r;
  logic [PO_W-1:0]  po_r;
  logic             bit_i;

  logic             out_valid_r;
  logic [RES_W-1:0] res_r;
  logic [RUN_W-1:0] run_r;
  logic             last_r;
  logic [ERR_W-1:0] err_r;

  logic             emit_c;
  logic [RES_W-1:0] res_c;
  logic [RUN_W-1:0] run_c;
  logic             last_c;
  logic [ERR_W-1:0] err_c;

  logic [31:0]      acc_sh;
  logic [4:0]       cnt_inc;
  logic [15:0]      per_raw, per_part;
  logic [15:0]      last_idx_w;
  logic             is_last;
  logic [3:0]       order_new;
  logic [15:0]      per_new;
  logic             part_bad;
  logic [4:0]       param_new;
  logic             esc_new;
  logic [4:0]       nbits_param;
  logic [15:0]      left_dec;
  logic [31:0]      rice_v;
  logic [31:0]      esc_mask, esc_m, esc_v;
  logic             param_done, sample_end;

  assign pop   = q_i.valid && (!out_valid_r || out_ch.ready);
  assign bit_i = q_i.item.stream_bit;
  assign eff   = q_i.item.section_start ? PST_RESET : st_r;

  assign acc_sh      = {eff.acc[30:0], bit_i};
  assign cnt_inc     = eff.cnt + 5'd1;
  assign per_raw     = bs_r >> eff.order;
  assign per_part    = (eff.pidx != '0) ? per_raw :
                       (per_raw > {10'd0, po_r}) ? per_raw - {10'd0, po_r} : 16'd0;
  assign last_idx_w  = (16'd1 << eff.order) - 16'd1;
  assign is_last     = (eff.pidx >= last_idx_w[14:0]);
  assign order_new   = acc_sh[3:0];
  assign per_new     = bs_r >> order_new;
  assign part_bad    = ((bs_r & ((16'd1 << order_new) - 16'd1)) != '0) ||
                       ({10'd0, po_r} > per_new);
  assign param_new   = acc_sh[4:0];
  assign esc_new     = (param_new == (eff.wide ? PARAM_ESC5 : PARAM_ESC4));
  assign nbits_param = eff.wide ? 5'd5 : 5'd4;
  assign param_done  = (cnt_inc == nbits_param);
  assign left_dec    = eff.left - 16'd1;
  assign sample_end  = (left_dec == '0);
  assign rice_v      = ({16'd0, eff.quot} << eff.kparam) | acc_sh;
  assign esc_mask    = (32'd1 << eff.escw) - 32'd1;
  assign esc_m       = acc_sh & esc_mask;
  assign esc_v       = acc_sh[5'(eff.escw - 5'd1)] ? (esc_m | ~esc_mask) : esc_m;

  // next parser state
  always_comb begin
    pstate_t s;
    s      = eff;
    st_nxt = eff;
    case (eff.phase)
      PH_METHOD: begin
        st_nxt.acc = acc_sh;
        st_nxt.cnt = cnt_inc;
        if (cnt_inc == METHOD_BITS) begin
          if (acc_sh[1]) begin
            st_nxt.phase = PH_HALT;
          end else begin
            st_nxt       = f_clear(eff);
            st_nxt.wide  = acc_sh[0];
            st_nxt.phase = PH_ORDER;
          end
        end
      end
      PH_ORDER: begin
        st_nxt.acc = acc_sh;
        st_nxt.cnt = cnt_inc;
        if (cnt_inc == ORDER_BITS) begin
          st_nxt       = f_clear(eff);
          st_nxt.order = order_new;
          if (part_bad) begin
            st_nxt.phase = PH_HALT;
          end else begin
            st_nxt.pidx  = '0;
            st_nxt.phase = PH_PARAM;
          end
        end
      end
      PH_PARAM: begin
        st_nxt.acc = acc_sh;
        st_nxt.cnt = cnt_inc;
        if (param_done) begin
          s        = f_clear(eff);
          s.kparam = param_new;
          s.esc    = esc_new;
          s.left   = per_part;
          if (esc_new) begin
            s.phase = PH_ESCW;
            st_nxt  = s;
          end else if (per_part == '0) begin
            st_nxt = f_advance(s, is_last);
          end else begin
            s.phase = PH_UNARY;
            st_nxt  = s;
          end
        end
      end
      PH_UNARY: begin
        if (!bit_i) begin
          if (eff.quot != 16'hFFFF) begin
            st_nxt.quot = eff.quot + 16'd1;
          end
        end else if (eff.kparam == '0) begin
          s      = f_clear(eff);
          s.left = left_dec;
          if (sample_end) begin
            st_nxt = f_advance(s, is_last);
          end else begin
            s.phase = PH_UNARY;
            st_nxt  = s;
          end
        end else begin
          st_nxt.cnt   = '0;
          st_nxt.acc   = '0;
          st_nxt.phase = PH_LOW;
        end
      end
      PH_LOW, PH_ESCS: begin
        st_nxt.acc = acc_sh;
        st_nxt.cnt = cnt_inc;
        if (cnt_inc >= ((eff.phase == PH_LOW) ? eff.kparam : eff.escw)) begin
          s      = f_clear(eff);
          s.left = left_dec;
          if (sample_end) begin
            st_nxt = f_advance(s, is_last);
          end else begin
            s.phase = eff.esc ? PH_ESCS : PH_UNARY;
            st_nxt  = s;
          end
        end
      end
      PH_ESCW: begin
        st_nxt.acc = acc_sh;
        st_nxt.cnt = cnt_inc;
        if (cnt_inc == ESCW_BITS) begin
          s      = f_clear(eff);
          s.escw = acc_sh[4:0];
          if (eff.left == '0) begin
            st_nxt = f_advance(s, is_last);
          end else if (acc_sh[4:0] == '0) begin
            s.left = '0;
            st_nxt = f_advance(s, is_last);
          end else begin
            s.phase = PH_ESCS;
            st_nxt  = s;
          end
        end
      end
      default: begin
        st_nxt = eff;
      end
    endcase
  end

  // result of this bit
  always_comb begin
    emit_c = 1'b0;
    res_c  = '0;
    run_c  = 16'd1;
    last_c = 1'b0;
    err_c  = ERR_NONE;
    case (eff.phase)
      PH_METHOD: begin
        if ((cnt_inc == METHOD_BITS) && acc_sh[1]) begin
          emit_c = 1'b1;
          run_c  = '0;
          last_c = 1'b1;
          err_c  = ERR_METHOD;
        end
      end
      PH_ORDER: begin
        if ((cnt_inc == ORDER_BITS) && part_bad) begin
          emit_c = 1'b1;
          run_c  = '0;
          last_c = 1'b1;
          err_c  = ERR_PART;
        end
      end
      PH_PARAM: begin
        if (param_done && !esc_new && (per_part == '0) && is_last) begin
          emit_c = 1'b1;
          run_c  = '0;
          last_c = 1'b1;
        end
      end
      PH_UNARY: begin
        if (bit_i && (eff.kparam == '0)) begin
          emit_c = 1'b1;
          res_c  = f_wrap(f_zigzag({16'd0, eff.quot}));
          last_c = sample_end && is_last;
        end
      end
      PH_LOW: begin
        if (cnt_inc >= eff.kparam) begin
          emit_c = 1'b1;
          res_c  = f_wrap(f_zigzag(rice_v));
          last_c = sample_end && is_last;
        end
      end
      PH_ESCS: begin
        if (cnt_inc >= eff.escw) begin
          emit_c = 1'b1;
          res_c  = f_wrap(esc_v);
          last_c = sample_end && is_last;
        end
      end
      PH_ESCW: begin
        if (cnt_inc == ESCW_BITS) begin
          if (eff.left == '0) begin
            emit_c = is_last;
            run_c  = '0;
            last_c = 1'b1;
          end else if (acc_sh[4:0] == '0) begin
            emit_c = 1'b1;
            run_c  = eff.left;
            last_c = is_last;
          end
        end
      end
      default: begin
        emit_c = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= PST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        st_r <= st_nxt;
      end
      if (pop && emit_c) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit_c) begin
      res_r  <= res_c;
      run_r  <= run_c;
      last_r <= last_c;
      err_r  <= err_c;
    end
  end

  // block registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= BS_RESET;
      po_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_BLOCK_SIZE: bs_r <= cfg_ch.data;
        CFG_PRED_ORDER: po_r <= cfg_ch.data[PO_W-1:0];
        default: begin
          bs_r <= bs_r;
        end
      endcase
    end
  end

  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.residual   = res_r;
  assign out_ch.run_count  = run_r;
  assign out_ch.block_last = last_r;
  assign out_ch.error_code = err_r;

endmodule

// File: rtl/rice_residual_decoder_core.sv
// ----------------------------------------------------------------------------
// rice_residual_decoder_core
// Partitioned Rice residual section decoder, one stream bit per request.
//
//   channel  dir  payload                                   handshake
//   in_ch    in   stream_bit, section_start                 valid/ready
//   out_ch   out  residual, run_count, block_last, error    valid/ready
//   cfg_ch   in   index (0 block_size, 1 predictor_order)   valid/ready
//
// one bit per clock sustained unless a result stalls on out_ch, set by the single-bit parser step
// a bit's result passes the queue register and the parser, then shows registered on out_ch
// synchronous active-low reset; block_size returns to 4096
// a four-entry queue keeps taking bits, until full, while a result waits on out_ch
// ----------------------------------------------------------------------------
module rice_residual_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  rrd_in_if.sink     in_ch,
  rrd_out_if.source  out_ch,
  rrd_cfg_if.sink    cfg_ch
);
  import rrd_pkg::*;

  qstat_t q;
  logic   pop;

  rrd_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_o   (q),
    .pop   (pop)
  );

  rrd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_i    (q),
    .pop    (pop),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

endmodule

// File: rtl/rrd_check.sv
// ----------------------------------------------------------------------------
// rrd_check
// Port-level checks on the result channel of the decoder.
// ----------------------------------------------------------------------------
module rrd_check (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [rrd_pkg::RES_W-1:0]        residual,
  input logic [rrd_pkg::RUN_W-1:0]        run_count,
  input logic                             block_last,
  input logic [rrd_pkg::ERR_W-1:0]        error_code
);
  import rrd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(residual) && $stable(run_count)
      && $stable(block_last) && $stable(error_code))
    else $error("result changed while stalled");

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (error_code != ERR_NONE) |-> block_last && (residual == '0)
      && (run_count == '0))
    else $error("error result not final or not empty");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (error_code == ERR_NONE) || (error_code == ERR_METHOD)
      || (error_code == ERR_PART))
    else $error("undefined error code");

  a_run_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !block_last |-> (run_count != '0))
    else $error("empty run on a non-final result");

endmodule

bind rice_residual_decoder_core rrd_check u_rrd_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .residual   (out_ch.residual),
  .run_count  (out_ch.run_count),
  .block_last (out_ch.block_last),
  .error_code (out_ch.error_code)
);
